FILE: sv/klp_pkg.sv
// ----------------------------------------------------------------------------
// klp_pkg
// shared types and constants of the key long-press detector
// ----------------------------------------------------------------------------
package klp_pkg;

  // timestamp arithmetic width
  localparam int TIME_BITS = 32;
  localparam logic [TIME_BITS-1:0] TIME_HALF = {1'b0, {(TIME_BITS-1){1'b1}}};

  // result queue geometry
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
  localparam int CNT_BITS   = $clog2(FIFO_DEPTH + 1);

  // register indexes on the write port
  localparam logic CFG_LONG_PRESS_MS = 1'b0;
  localparam logic CFG_KEY_CODE      = 1'b1;

  // input kinds
  localparam logic [1:0] KIND_DOWN = 2'd0;
  localparam logic [1:0] KIND_UP   = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  // result codes
  localparam logic [1:0] EV_SHORT         = 2'd0;
  localparam logic [1:0] EV_LONG_DETECTED = 2'd1;
  localparam logic [1:0] EV_LONG_RELEASED = 2'd2;

  // results of one event, second one is always the final one
  typedef struct packed {
    logic [1:0] count;
    logic [1:0] ev0;
    logic       last0;
    logic [1:0] ev1;
  } klp_res_t;

endpackage

FILE: sv/klp_classifier.sv
// ----------------------------------------------------------------------------
// klp_classifier
// press mode tracking, elapsed-time test and result generation per event
// ----------------------------------------------------------------------------
module klp_classifier (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  logic [1:0]                    kind,
  input  logic [klp_pkg::TIME_BITS-1:0] now,
  input  logic [15:0]                   delay,
  output klp_pkg::klp_res_t             res
);

  typedef enum logic [1:0] {
    MODE_RELEASED = 2'd0,
    MODE_HELD     = 2'd1,
    MODE_TIMEOUT  = 2'd2
  } mode_t;

  mode_t                          mode;
  mode_t                          mode_next;
  logic [klp_pkg::TIME_BITS-1:0]  hold_start;
  logic [klp_pkg::TIME_BITS-1:0]  hold_start_next;

  logic [klp_pkg::TIME_BITS-1:0]  delay_ext;
  logic [klp_pkg::TIME_BITS-1:0]  end_a;
  logic [klp_pkg::TIME_BITS-1:0]  start_h;
  logic [klp_pkg::TIME_BITS-1:0]  now_h;
  logic [klp_pkg::TIME_BITS-1:0]  end_h;
  logic                           direct;
  logic                           elapsed;
  klp_pkg::klp_res_t              res_c;

  // modular elapsed test, shifted by half range when the plain compare is unsafe
  always_comb begin
    delay_ext = {{(klp_pkg::TIME_BITS-16){1'b0}}, delay};
    end_a     = hold_start + delay_ext;
    start_h   = hold_start + klp_pkg::TIME_HALF;
    now_h     = now + klp_pkg::TIME_HALF;
    end_h     = start_h + delay_ext;
    direct    = (hold_start < now) && (hold_start <= end_a);
    elapsed   = direct ? (end_a < now) : (end_h < now_h);
  end

  always_comb begin
    mode_next       = mode;
    hold_start_next = hold_start;
    res_c.count     = 2'd0;
    res_c.ev0       = klp_pkg::EV_SHORT;
    res_c.last0     = 1'b1;
    res_c.ev1       = klp_pkg::EV_LONG_RELEASED;
    case (mode)
      MODE_HELD: begin
        if (kind == klp_pkg::KIND_UP) begin
          mode_next = MODE_RELEASED;
          if (elapsed) begin
            res_c.count = 2'd2;
            res_c.ev0   = klp_pkg::EV_LONG_DETECTED;
            res_c.last0 = 1'b0;
          end else begin
            res_c.count = 2'd1;
          end
        end else if (kind == klp_pkg::KIND_TICK && elapsed) begin
          mode_next   = MODE_TIMEOUT;
          res_c.count = 2'd1;
          res_c.ev0   = klp_pkg::EV_LONG_DETECTED;
        end
      end
      MODE_TIMEOUT: begin
        if (kind == klp_pkg::KIND_UP) begin
          mode_next   = MODE_RELEASED;
          res_c.count = 2'd1;
          res_c.ev0   = klp_pkg::EV_LONG_RELEASED;
        end
      end
      default: begin
        if (kind == klp_pkg::KIND_DOWN) begin
          mode_next       = MODE_HELD;
          hold_start_next = now;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_RELEASED;
      hold_start <= '0;
    end else if (fire) begin
      mode       <= mode_next;
      hold_start <= hold_start_next;
    end
  end

  always_comb begin
    res       = res_c;
    res.count = fire ? res_c.count : 2'd0;
  end

  a_down_loads_start: assert property (@(posedge clk) disable iff (rst)
    (fire && mode == MODE_RELEASED && kind == klp_pkg::KIND_DOWN)
      |=> (mode == MODE_HELD && hold_start == $past(now)))
    else $error("key-down did not start a hold");

  a_two_only_on_held_up: assert property (@(posedge clk) disable iff (rst)
    (res.count == 2'd2) |-> (mode == MODE_HELD && kind == klp_pkg::KIND_UP))
    else $error("two results outside a key-up in held mode");

  a_idle_keeps_state: assert property (@(posedge clk) disable iff (rst)
    !fire |=> ($stable(mode) && $stable(hold_start)))
    else $error("state changed without an event");

  a_timeout_from_held: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_TIMEOUT && $past(mode) != MODE_TIMEOUT)
      |-> ($past(mode) == MODE_HELD && $past(kind) == klp_pkg::KIND_TICK))
    else $error("timeout mode entered without a tick while held");

endmodule

FILE: sv/klp_result_fifo.sv
// ----------------------------------------------------------------------------
// klp_result_fifo
// small result queue, up to two pushes and one pop per cycle
// ----------------------------------------------------------------------------
module klp_result_fifo (
  input  logic              clk,
  input  logic              rst,
  input  klp_pkg::klp_res_t push,
  input  logic              pop,
  output logic              valid,
  output logic [1:0]        ev,
  output logic              last,
  output logic              room2
);

  logic [2:0]                   mem [klp_pkg::FIFO_DEPTH];
  logic [klp_pkg::PTR_BITS-1:0] wp;
  logic [klp_pkg::PTR_BITS-1:0] rp;
  logic [klp_pkg::CNT_BITS-1:0] count;
  logic [klp_pkg::PTR_BITS-1:0] wp1;

  assign wp1   = wp + klp_pkg::PTR_BITS'(1);
  assign valid = (count != '0);
  assign ev    = mem[rp][2:1];
  assign last  = mem[rp][0];
  assign room2 = (count <= klp_pkg::CNT_BITS'(klp_pkg::FIFO_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + klp_pkg::PTR_BITS'(push.count);
      rp    <= rp + klp_pkg::PTR_BITS'(pop);
      count <= count + klp_pkg::CNT_BITS'(push.count) - klp_pkg::CNT_BITS'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wp] <= {push.ev0, push.last0};
    end
    if (push.count == 2'd2) begin
      mem[wp1] <= {push.ev1, 1'b1};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= klp_pkg::CNT_BITS'(klp_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> room2)
    else $error("push into a queue without room");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> valid)
    else $error("pop from an empty queue");

  a_drain_last: assert property (@(posedge clk) disable iff (rst)
    (count == klp_pkg::CNT_BITS'(1) && pop && push.count == 2'd0) |=> !valid)
    else $error("queue not empty after draining its last entry");

endmodule

FILE: sv/key_long_press_detector.sv
// ----------------------------------------------------------------------------
// key_long_press_detector
// classifies presses of one key as short, long detected or long released
// ----------------------------------------------------------------------------
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  events   | in_valid, in_ready, kind, time_ms         | in
//  results  | out_valid, out_ready, press_event, key_id, | out
//           | last                                      |
//  config   | cfg_we, cfg_index, cfg_data               | in
//
//  an event is registered on transfer and classified once the queue has room;
//  its results enter a four-entry queue; its head entry drives the outputs
//  one event per cycle is taken while the queue has room for two results;
//  a long key-up gives two results, which leave at one per cycle if out_ready
//  reset clears the press mode, hold timestamp and queue and loads the
//  register defaults (900 ms, key 0)
//  a stalled output fills the queue, then in_ready drops until room2 returns
//
module key_long_press_detector (
  input  logic        clk,
  input  logic        rst,
  // event channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [31:0] time_ms,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  press_event,
  output logic [7:0]  key_id,
  output logic        last,
  // register writes
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  // configuration registers
  logic [15:0] long_press_ms;
  logic [7:0]  key_code;

  // event register
  logic        ev_valid;
  logic [1:0]  kind_r;
  logic [31:0] time_r;

  logic              fire;
  logic              room2;
  logic              in_xfer;
  klp_pkg::klp_res_t res;

  // classify the held event once the queue can take both possible results
  assign fire     = ev_valid && room2;
  assign in_ready = !ev_valid || fire;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ms <= 16'd900;
      key_code      <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        klp_pkg::CFG_LONG_PRESS_MS: long_press_ms <= cfg_data;
        klp_pkg::CFG_KEY_CODE:      key_code      <= cfg_data[7:0];
        default:                    key_code      <= key_code;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (in_xfer) begin
      ev_valid <= 1'b1;
    end else if (fire) begin
      ev_valid <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      kind_r <= kind;
      time_r <= time_ms;
    end
  end

  klp_classifier u_classifier (
    .clk   (clk),
    .rst   (rst),
    .fire  (fire),
    .kind  (kind_r),
    .now   (time_r[klp_pkg::TIME_BITS-1:0]),
    .delay (long_press_ms),
    .res   (res)
  );

  klp_result_fifo u_result_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (res),
    .pop   (out_valid && out_ready),
    .valid (out_valid),
    .ev    (press_event),
    .last  (last),
    .room2 (room2)
  );

  // registers must only change while block is idle (unenforced); id is live
  assign key_id = key_code;

endmodule

FILE: dv/tb_key_long_press_detector.sv
// ----------------------------------------------------------------------------
// tb_key_long_press_detector
// self-checking bench for the short/long key press classifier
//
// A queue of key events drives the event channel. Each event is classified
// by a local copy of the press logic when it is accepted, and the expected
// results are checked in order against the result channel. The run starts
// with directed presses and then applies random press sequences under several
// register settings, with three idle patterns on the two channels.
// ----------------------------------------------------------------------------
module tb_key_long_press_detector;
  timeunit 1ns;
  timeprecision 1ps;

  // event kind the block must ignore
  localparam logic [1:0] KIND_SPARE = 2'd3;

  // cycles a result may still be in the pipe after the last one has come out
  localparam int SETTLE_CYCLES = 8;
  // cycles with no transfer on either channel before the run is abandoned
  localparam int STALL_LIMIT   = 4000;
  // counted random events for each register setting
  localparam int EVENTS_PER_SETTING = 316;

  typedef enum logic [1:0] {KEY_RELEASED, KEY_HELD, KEY_TIMED_OUT} key_mode_t;

  typedef struct packed {
    logic [1:0]  code;
    logic [31:0] stamp;
  } key_event_t;

  typedef struct packed {
    logic [1:0] ev;
    logic [7:0] key;
    logic       last;
  } press_result_t;

  // dut ports
  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  kind = klp_pkg::KIND_DOWN;
  logic [31:0] time_ms = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  press_event;
  logic [7:0]  key_id;
  logic        last;
  logic        cfg_we = 1'b0;
  logic        cfg_index = klp_pkg::CFG_LONG_PRESS_MS;
  logic [15:0] cfg_data = '0;

  // stimulus and expectations
  key_event_t    pending_events[$];
  press_result_t due_results[$];
  int            n_queued = 0;
  int            n_accepted = 0;
  int            err_count = 0;
  int            stall_cycles = 0;
  logic          in_xfer = 1'b0;

  // idle chances in percent, changed per part of the run
  int unsigned   snd_idle_pct = 0;
  int unsigned   rcv_idle_pct = 0;

  // local copy of the press classifier
  key_mode_t     press_mode = KEY_RELEASED;
  logic [31:0]   hold_ts = '0;
  logic [15:0]   long_ms = 16'd900;
  logic [7:0]    key_sel = 8'd0;

  // running millisecond clock of the random press generator
  logic [31:0]   clock_ms = 32'd10000;

  key_long_press_detector dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .time_ms    (time_ms),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .press_event(press_event),
    .key_id     (key_id),
    .last       (last),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // press classifier
  // --------------------------------------------------------------------------

  // modular elapsed test: plain compare when start < now and start+delay does
  // not wrap, otherwise both sides are shifted by half the range first
  function automatic logic hold_elapsed(input logic [31:0] start,
                                        input logic [31:0] now,
                                        input logic [15:0] dly);
    logic [31:0] fin;
    logic [31:0] s_sh;
    logic [31:0] n_sh;
    fin = start + {16'd0, dly};
    if (start < now && start <= fin)
      return fin < now;
    s_sh = start + klp_pkg::TIME_HALF;
    n_sh = now + klp_pkg::TIME_HALF;
    fin  = s_sh + {16'd0, dly};
    return fin < n_sh;
  endfunction

  // update the mode for one accepted event and queue the results it gives
  task automatic classify_key_event(input logic [1:0] code, input logic [31:0] now);
    case (press_mode)
      KEY_HELD: begin
        if (code == klp_pkg::KIND_UP) begin
          press_mode = KEY_RELEASED;
          if (hold_elapsed(hold_ts, now, long_ms)) begin
            // long release reports the detection first, then the release
            due_results.push_back('{klp_pkg::EV_LONG_DETECTED, key_sel, 1'b0});
            due_results.push_back('{klp_pkg::EV_LONG_RELEASED, key_sel, 1'b1});
          end else begin
            due_results.push_back('{klp_pkg::EV_SHORT, key_sel, 1'b1});
          end
        end else if (code == klp_pkg::KIND_TICK && hold_elapsed(hold_ts, now, long_ms)) begin
          press_mode = KEY_TIMED_OUT;
          due_results.push_back('{klp_pkg::EV_LONG_DETECTED, key_sel, 1'b1});
        end
        // repeated key-down, early tick and spare kind do nothing
      end
      KEY_TIMED_OUT: begin
        if (code == klp_pkg::KIND_UP) begin
          press_mode = KEY_RELEASED;
          due_results.push_back('{klp_pkg::EV_LONG_RELEASED, key_sel, 1'b1});
        end
      end
      default: begin
        // released: only a key-down starts a hold, stray key-ups are dropped
        if (code == klp_pkg::KIND_DOWN) begin
          press_mode = KEY_HELD;
          hold_ts    = now;
        end
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  task automatic push_event(input logic [1:0] code, input logic [31:0] stamp);
    pending_events.push_back('{code, stamp});
    n_queued++;
  endtask

  // wait until every event is taken and every result has come, then let the
  // pipe run empty in case the last event gave no result
  task automatic settle();
    do @(negedge clk);
    while (n_accepted != n_queued || due_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // one register write, only called while the block is idle
  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    if (idx == klp_pkg::CFG_LONG_PRESS_MS)
      long_ms = val;
    else
      key_sel = val[7:0];
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // mostly complete presses with hold times spread around the threshold,
  // the rest stray events of any kind and any timestamp
  task automatic queue_random_presses(input int goal);
    int          added;
    int          n_ticks;
    logic [31:0] start;
    logic [31:0] hold;
    logic [31:0] dly;
    logic [31:0] t;
    logic [1:0]  code;
    added = 0;
    dly   = {16'd0, long_ms};
    while (added < goal) begin
      if ($urandom_range(99) < 80) begin
        // occasional jump anywhere so the timestamp wraps
        if ($urandom_range(9) == 0)
          clock_ms = $urandom();
        else
          clock_ms = clock_ms + $urandom_range(1, 3000);
        start = clock_ms;
        case ($urandom_range(3))
          0:       hold = $urandom_range(0, dly);
          1:       hold = dly + $urandom_range(0, 4) - 32'd2;
          2:       hold = dly + $urandom_range(1, 2000);
          default: hold = $urandom();
        endcase
        push_event(klp_pkg::KIND_DOWN, start);
        added++;
        n_ticks = $urandom_range(0, 3);
        for (int j = 1; j <= n_ticks; j++) begin
          t = start + (hold / (n_ticks + 1)) * j + $urandom_range(0, 3);
          push_event(klp_pkg::KIND_TICK, t);
          added++;
          if ($urandom_range(7) == 0)
            push_event(klp_pkg::KIND_DOWN, t);
        end
        // now and then the key stays down and the next press is swallowed
        if ($urandom_range(9) != 0) begin
          push_event(klp_pkg::KIND_UP, start + hold);
          added++;
        end
        clock_ms = start + hold;
      end else begin
        code = 2'($urandom_range(0, 3));
        if ($urandom_range(1) == 0)
          t = $urandom();
        else
          t = clock_ms + $urandom_range(0, dly + 100);
        push_event(code, t);
        if (code != KIND_SPARE)
          added++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // event driver and result ready, both change at the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : drive_events
    key_event_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_xfer) begin
      // free to move on: the previous event was taken or none was offered
      if (pending_events.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
        nxt = pending_events.pop_front();
        in_valid <= 1'b1;
        kind     <= nxt.code;
        time_ms  <= nxt.stamp;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // --------------------------------------------------------------------------
  // monitor: checks results, predicts accepted events, watches for a hang
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watch_channels
    press_result_t want;
    if (rst) begin
      in_xfer <= 1'b0;
    end else begin
      in_xfer <= in_valid && in_ready;

      // result transfer first, it always belongs to an earlier event
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("unexpected result: ev=%0d key=%0d last=%0d",
                     press_event, key_id, last);
        end else begin
          want = due_results.pop_front();
          if (press_event !== want.ev || key_id !== want.key || last !== want.last) begin
            err_count++;
            if (err_count <= 10)
              $display("mismatch: expected ev=%0d key=%0d last=%0d, got ev=%0d key=%0d last=%0d",
                       want.ev, want.key, want.last, press_event, key_id, last);
          end
        end
      end

      if (in_valid && in_ready) begin
        classify_key_event(kind, time_ms);
        n_accepted++;
      end

      // watchdog on cycles with no transfer at all
      if ((in_valid && in_ready) || (out_valid && out_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin : run_test
    logic [15:0] dly;
    logic [7:0]  key;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // first pattern: few sender gaps, heavy result back-pressure
    @(posedge clk);
    snd_idle_pct = 8;
    rcv_idle_pct = 79;

    // reset defaults: 900 ms threshold, key 0
    push_event(klp_pkg::KIND_DOWN, 32'd10);
    push_event(klp_pkg::KIND_UP,   32'd500);
    push_event(klp_pkg::KIND_DOWN, 32'd1000);
    push_event(klp_pkg::KIND_UP,   32'd1901);

    settle();
    write_reg(klp_pkg::CFG_LONG_PRESS_MS, 16'd100);
    write_reg(klp_pkg::CFG_KEY_CODE,      16'h00A5);
    @(posedge clk);
    // stray key-up, tick and spare kind while released
    push_event(klp_pkg::KIND_UP,   32'd1950);
    push_event(klp_pkg::KIND_TICK, 32'd1960);
    push_event(KIND_SPARE,         32'd1970);
    // repeated key-down, spare kind while held, key-up exactly on the threshold
    push_event(klp_pkg::KIND_DOWN, 32'd2000);
    push_event(klp_pkg::KIND_DOWN, 32'd2010);
    push_event(KIND_SPARE,         32'd2020);
    push_event(klp_pkg::KIND_TICK, 32'd2050);
    push_event(klp_pkg::KIND_UP,   32'd2100);
    // tick past the threshold, then tick and key-down while timed out
    push_event(klp_pkg::KIND_DOWN, 32'd3000);
    push_event(klp_pkg::KIND_TICK, 32'd3101);
    push_event(klp_pkg::KIND_TICK, 32'd3200);
    push_event(klp_pkg::KIND_DOWN, 32'd3300);
    push_event(klp_pkg::KIND_UP,   32'd3400);
    // long release straight from held
    push_event(klp_pkg::KIND_DOWN, 32'd4000);
    push_event(klp_pkg::KIND_UP,   32'd4101);
    // now below start, shifted compare
    push_event(klp_pkg::KIND_DOWN, 32'hFFFF_FFC0);
    push_event(klp_pkg::KIND_UP,   32'h0000_0100);
    // timestamp extremes
    push_event(klp_pkg::KIND_DOWN, 32'h0000_0000);
    push_event(klp_pkg::KIND_UP,   32'hFFFF_FFFF);
    // start plus delay wraps past the top
    push_event(klp_pkg::KIND_DOWN, 32'hFFFF_FFF0);
    push_event(klp_pkg::KIND_UP,   32'hFFFF_FFF8);

    // random part, two settings per idle pattern
    for (int s = 0; s < 6; s++) begin
      // every change of setting waits for a fully drained block
      settle();
      case (s)
        0:       begin dly = 16'd0;     key = 8'd0;   end
        1:       begin dly = 16'hFFFF;  key = 8'hFF;  end
        2:       begin dly = 16'd900;   key = 8'($urandom_range(0, 255)); end
        3:       begin
          dly = 16'($urandom_range(1, 200));
          key = 8'($urandom_range(0, 255));
        end
        4:       begin
          dly = 16'($urandom_range(0, 65535));
          key = 8'($urandom_range(0, 255));
        end
        default: begin
          dly = 16'($urandom_range(1, 50));
          key = 8'($urandom_range(0, 255));
        end
      endcase
      write_reg(klp_pkg::CFG_LONG_PRESS_MS, dly);
      write_reg(klp_pkg::CFG_KEY_CODE,      {8'd0, key});
      @(posedge clk);
      case (s / 2)
        0:       begin snd_idle_pct = 8;  rcv_idle_pct = 79; end
        1:       begin snd_idle_pct = 79; rcv_idle_pct = 8;  end
        default: begin snd_idle_pct = 0;  rcv_idle_pct = 0;  end
      endcase
      queue_random_presses(EVENTS_PER_SETTING);
    end

    settle();
    if (due_results.size() != 0)
      err_count++;
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: files.f
sv/klp_pkg.sv
sv/klp_classifier.sv
sv/klp_result_fifo.sv
sv/key_long_press_detector.sv
dv/tb_key_long_press_detector.sv
